@@ rtl/core/pbts_pkg.sv @@
// Package for the packed beat tone sequencer: shared types, widths, register
// indexes and the semitone period table.
// No dependencies; every other file in rtl/core uses it by scoped names.
package pbts_pkg;

    localparam int CFG_W        = 24;   // width of each configuration register
    localparam int CFG_IDX_W    = 2;
    localparam int BEAT_W       = 28;   // beat timer
    localparam int WAVE_W       = 21;   // note period, half waves, wave counter
    localparam int KMIN_W       = 16;   // ticks_per_second / 400
    localparam int KSTEP_W      = 15;   // (3 * kick_min) / 5
    localparam int KLIM_W       = 18;   // 4 * kick_min
    localparam int KPER_W       = 19;   // kick half period, may pass the limit by one step
    localparam int SEMI_W       = 24;
    localparam int OCT_W        = 4;
    localparam int NOISE_W      = 32;
    localparam int NBIT_W       = 5;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QPTR_W       = 3;
    localparam int QCNT_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BEAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNARE_TICKS      = 2'd2;

    localparam logic [CFG_W-1:0] TPS_RESET   = 24'd210000;
    localparam logic [CFG_W-1:0] TPB_RESET   = 24'd52500;
    localparam logic [CFG_W-1:0] SNARE_RESET = 24'd10500;

    localparam logic [NOISE_W-1:0] NOISE_SEED = 32'h0BADC0DE;

    // (2^30 + 1) / 25 and (2^18 + 1) / 5: exact reciprocals over the value ranges used
    localparam logic [25:0] DIV25_RECIP = 26'd42949673;
    localparam logic [15:0] DIV5_RECIP  = 16'd52429;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KICK,
        PH_SNARE,
        PH_NOTE,
        PH_REST
    } pbts_phase_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic              is_load;
        logic              kick;
        logic              snare;
        logic              nz;          // note period is nonzero
        logic [BEAT_W-1:0] beat_ticks;
        logic [WAVE_W-1:0] on_ticks;
        logic [WAVE_W-1:0] off_ticks;
    } pbts_item_t;

    // Values derived from configuration, used by the back
    typedef struct packed {
        logic [KMIN_W-1:0]  kick_min;
        logic [KSTEP_W-1:0] kick_step;
        logic [KLIM_W-1:0]  kick_limit;
        logic [CFG_W-1:0]   snare_ticks;
    } pbts_cfg_t;

    // round(2^24 * 2^((105 - r) / 12) / 440), Q0.24
    function automatic logic [SEMI_W-1:0] semitone(input logic [OCT_W-1:0] r);
        logic [SEMI_W-1:0] v;
        begin
            unique case (r)
                4'd0:    v = 24'd16416466;
                4'd1:    v = 24'd15495081;
                4'd2:    v = 24'd14625409;
                4'd3:    v = 24'd13804548;
                4'd4:    v = 24'd13029758;
                4'd5:    v = 24'd12298454;
                4'd6:    v = 24'd11608195;
                4'd7:    v = 24'd10956677;
                4'd8:    v = 24'd10341726;
                4'd9:    v = 24'd9761289;
                4'd10:   v = 24'd9213430;
                4'd11:   v = 24'd8696320;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/core/pbts_front.sv @@
// Front of the tone sequencer: configuration registers, kick constants, and a
// three-stage pipeline that works out beat length and note half periods.
// Depends on pbts_pkg.
module pbts_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           wr_en,
    input  logic [pbts_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pbts_pkg::CFG_W-1:0]     wr_data,
    input  logic                           pop,
    output logic                           push,
    output pbts_pkg::pbts_item_t           push_item,
    output pbts_pkg::pbts_cfg_t            cfg
);

    logic [pbts_pkg::CFG_W-1:0] tps_reg;
    logic [pbts_pkg::CFG_W-1:0] tpb_reg;
    logic [pbts_pkg::CFG_W-1:0] snare_reg;

    logic [45:0] kmul_reg;
    logic [45:0] kmul_next;
    logic [33:0] smul_reg;
    logic [33:0] smul_next;
    logic [pbts_pkg::KMIN_W-1:0]  kick_min;
    logic [pbts_pkg::KSTEP_W-1:0] step_raw;
    logic [17:0] kick_x3;

    logic [pbts_pkg::QCNT_W-1:0] credit_reg;
    logic [pbts_pkg::QCNT_W-1:0] credit_next;
    logic accept;

    // stage 1: decoded word
    logic                           v1_reg;
    logic                           load1_reg;
    logic                           kick1_reg;
    logic                           snare1_reg;
    logic                           nzn1_reg;
    logic [1:0]                     duty1_reg;
    logic [4:0]                     beats1_reg;
    logic [pbts_pkg::OCT_W-1:0]     oct1_reg;
    logic [pbts_pkg::SEMI_W-1:0]    semi1_reg;
    logic [6:0]                     note;
    logic [12:0]                    note_x43;
    logic [pbts_pkg::OCT_W-1:0]     oct_next;
    logic [6:0]                     rem_full;

    // stage 2: partial products
    logic                           v2_reg;
    logic                           load2_reg;
    logic                           kick2_reg;
    logic                           snare2_reg;
    logic                           nzn2_reg;
    logic [1:0]                     duty2_reg;
    logic [pbts_pkg::OCT_W-1:0]     oct2_reg;
    logic [35:0]                    plo2_reg;
    logic [35:0]                    phi2_reg;
    logic [pbts_pkg::BEAT_W-1:0]    bt2_reg;
    logic [28:0]                    bt_prod;

    // stage 3: full product, scaled by 2^-27
    logic                           v3_reg;
    logic                           load3_reg;
    logic                           kick3_reg;
    logic                           snare3_reg;
    logic [1:0]                     duty3_reg;
    logic [pbts_pkg::OCT_W-1:0]     oct3_reg;
    logic [pbts_pkg::WAVE_W-1:0]    p27_3_reg;
    logic [pbts_pkg::BEAT_W-1:0]    bt3_reg;
    logic [47:0]                    prod_sum;

    logic [pbts_pkg::WAVE_W-1:0]    period;
    logic [pbts_pkg::WAVE_W-1:0]    on_ticks;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= pbts_pkg::TPS_RESET;
            tpb_reg   <= pbts_pkg::TPB_RESET;
            snare_reg <= pbts_pkg::SNARE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pbts_pkg::REG_TICKS_PER_SECOND: tps_reg   <= wr_data;
                pbts_pkg::REG_TICKS_PER_BEAT:   tpb_reg   <= wr_data;
                pbts_pkg::REG_SNARE_TICKS:      snare_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // kick_min = tps / 400 = (tps >> 4) / 25; step = (3 * kick_min) / 5
    assign kmul_next = 46'(tps_reg[pbts_pkg::CFG_W-1:4]) * 46'(pbts_pkg::DIV25_RECIP);
    assign kick_min  = kmul_reg[45:30];
    assign kick_x3   = 18'(kick_min) + {1'b0, kick_min, 1'b0};
    assign smul_next = 34'(kick_x3) * 34'(pbts_pkg::DIV5_RECIP);
    assign step_raw  = smul_reg[32:18];

    always_ff @(posedge clk)
    begin
        kmul_reg <= kmul_next;
        smul_reg <= smul_next;
    end

    always_comb
    begin
        cfg.kick_min    = kick_min;
        cfg.kick_step   = (step_raw == '0) ? pbts_pkg::KSTEP_W'(1) : step_raw;
        cfg.kick_limit  = {kick_min, 2'b00};
        cfg.snare_ticks = snare_reg;
    end

    // credits cover the pipeline and the queue, so the queue never overflows
    assign s_tready    = credit_reg < pbts_pkg::QCNT_W'(pbts_pkg::QUEUE_DEPTH);
    assign accept      = s_tvalid && s_tready;
    assign credit_next = credit_reg + pbts_pkg::QCNT_W'(accept) - pbts_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
        end
    end

    // octave = note / 12 via note * 43 >> 9, exact for 7-bit notes
    assign note     = s_tdata[14:8];
    assign note_x43 = 13'(note) * 13'd43;
    assign oct_next = note_x43[12:9];
    assign rem_full = note - 7'(oct_next) * 7'd12;

    always_ff @(posedge clk)
    begin
        load1_reg  <= s_tuser[0];
        kick1_reg  <= s_tdata[4];
        snare1_reg <= s_tdata[5];
        nzn1_reg   <= note != '0;
        duty1_reg  <= s_tdata[7:6];
        beats1_reg <= 5'(s_tdata[3:0]) + 5'd1;
        oct1_reg   <= oct_next;
        semi1_reg  <= pbts_pkg::semitone(rem_full[pbts_pkg::OCT_W-1:0]);
    end

    assign bt_prod = 29'(tpb_reg) * 29'(beats1_reg);

    always_ff @(posedge clk)
    begin
        load2_reg  <= load1_reg;
        kick2_reg  <= kick1_reg;
        snare2_reg <= snare1_reg;
        nzn2_reg   <= nzn1_reg;
        duty2_reg  <= duty1_reg;
        oct2_reg   <= oct1_reg;
        plo2_reg   <= 36'(tps_reg) * 36'(semi1_reg[11:0]);
        phi2_reg   <= 36'(tps_reg) * 36'(semi1_reg[23:12]);
        bt2_reg    <= bt_prod[pbts_pkg::BEAT_W-1:0];
    end

    assign prod_sum = 48'(plo2_reg) + {phi2_reg, 12'b0};

    always_ff @(posedge clk)
    begin
        load3_reg  <= load2_reg;
        kick3_reg  <= kick2_reg;
        snare3_reg <= snare2_reg;
        duty3_reg  <= duty2_reg;
        oct3_reg   <= oct2_reg;
        bt3_reg    <= bt2_reg;
        p27_3_reg  <= nzn2_reg ? prod_sum[47:27] : '0;
    end

    // octave shift, then split the period into high and low halves
    assign period   = p27_3_reg >> oct3_reg;
    assign on_ticks = period >> ({1'b0, duty3_reg} + 3'd1);

    assign push = v3_reg;

    always_comb
    begin
        push_item.is_load    = load3_reg;
        push_item.kick       = kick3_reg;
        push_item.snare      = snare3_reg;
        push_item.nz         = period != '0;
        push_item.beat_ticks = bt3_reg;
        push_item.on_ticks   = on_ticks;
        push_item.off_ticks  = period - on_ticks;
    end

endmodule

@@ rtl/core/pbts_queue.sv @@
// Short queue of classified items between the front and the back.
// Depends on pbts_pkg.
module pbts_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pbts_pkg::pbts_item_t push_item,
    input  logic                 pop,
    output logic                 head_valid,
    output pbts_pkg::pbts_item_t head_item
);

    pbts_pkg::pbts_item_t entries_reg [pbts_pkg::QUEUE_DEPTH];

    logic [pbts_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pbts_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pbts_pkg::QCNT_W-1:0] count_reg;
    logic [pbts_pkg::QCNT_W-1:0] count_next;

    assign head_valid = count_reg != '0;
    assign head_item  = entries_reg[rd_ptr_reg];
    assign count_next = count_reg + pbts_pkg::QCNT_W'(push) - pbts_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pbts_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pbts_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/pbts_back.sv @@
// Back of the tone sequencer: play state machine for kick, snare, note and
// rest with a registered result stage; one item per cycle unless stalled.
// Depends on pbts_pkg.
module pbts_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  pbts_pkg::pbts_item_t head_item,
    input  pbts_pkg::pbts_cfg_t  cfg,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);

    pbts_pkg::pbts_phase_t phase_reg;
    pbts_pkg::pbts_phase_t phase_next;

    logic [pbts_pkg::BEAT_W-1:0]  beat_timer_reg;
    logic [pbts_pkg::BEAT_W-1:0]  beat_timer_next;
    logic [pbts_pkg::NOISE_W-1:0] noise_reg;
    logic [pbts_pkg::NOISE_W-1:0] noise_next;
    logic [pbts_pkg::WAVE_W-1:0]  wave_cnt_reg;
    logic [pbts_pkg::WAVE_W-1:0]  wave_cnt_next;
    logic                         half_high_reg;
    logic                         half_high_next;
    logic [pbts_pkg::KPER_W-1:0]  kick_period_reg;
    logic [pbts_pkg::KPER_W-1:0]  kick_period_next;
    logic [pbts_pkg::CFG_W-1:0]   snare_timer_reg;
    logic [pbts_pkg::CFG_W-1:0]   snare_timer_next;
    logic [pbts_pkg::WAVE_W-1:0]  on_ticks_reg;
    logic [pbts_pkg::WAVE_W-1:0]  on_ticks_next;
    logic [pbts_pkg::WAVE_W-1:0]  off_ticks_reg;
    logic [pbts_pkg::WAVE_W-1:0]  off_ticks_next;
    logic                         note_nz_reg;
    logic                         note_nz_next;
    logic [pbts_pkg::NBIT_W-1:0]  bit_idx_reg;
    logic [pbts_pkg::NBIT_W-1:0]  bit_idx_next;
    logic                         pin_reg;
    logic                         pin_next;

    logic       out_valid_reg;
    logic [2:0] out_data_reg;
    logic       refused;

    logic busy;
    logic do_load;
    logic do_tick;
    logic kick_go;
    logic snare_go;
    logic [pbts_pkg::BEAT_W-1:0]  bt_dec;
    logic [pbts_pkg::WAVE_W-1:0]  wc_dec;
    logic                         wc_end;
    logic [pbts_pkg::KPER_W-1:0]  kp_inc;
    logic                         kick_more;
    logic [pbts_pkg::CFG_W-1:0]   sn_dec;
    logic                         sn_end;
    logic [pbts_pkg::NOISE_W-1:0] noise_cur;
    logic                         load_note_go;
    logic                         tick_note_go;
    logic                         per_half;
    logic [pbts_pkg::WAVE_W-1:0]  per_wc;
    logic                         load_half;
    logic [pbts_pkg::WAVE_W-1:0]  load_wc;

    function automatic logic [pbts_pkg::NOISE_W-1:0] xorshift(
        input logic [pbts_pkg::NOISE_W-1:0] x
    );
        logic [pbts_pkg::NOISE_W-1:0] a;
        logic [pbts_pkg::NOISE_W-1:0] b;
        begin
            a = x ^ (x << 13);
            b = a ^ (a >> 17);
            return b ^ (b << 5);
        end
    endfunction

    // phase after the percussion part or at a load without percussion
    function automatic pbts_pkg::pbts_phase_t note_phase(input logic bt_zero, input logic nz);
        begin
            if (bt_zero)
            begin
                return pbts_pkg::PH_IDLE;
            end
            else if (nz)
            begin
                return pbts_pkg::PH_NOTE;
            end
            return pbts_pkg::PH_REST;
        end
    endfunction

    assign pop     = head_valid && (!out_valid_reg || m_tready);
    assign busy    = phase_reg != pbts_pkg::PH_IDLE;
    assign do_load = pop && head_item.is_load && !busy;
    assign do_tick = pop && !head_item.is_load;
    assign refused = pop && head_item.is_load && busy;

    assign kick_go  = head_item.kick && (cfg.kick_min != '0);
    assign snare_go = !head_item.kick && head_item.snare && (cfg.snare_ticks != '0);

    assign bt_dec    = beat_timer_reg - pbts_pkg::BEAT_W'(beat_timer_reg != '0);
    assign wc_dec    = wave_cnt_reg - pbts_pkg::WAVE_W'(wave_cnt_reg != '0);
    assign wc_end    = wc_dec == '0;
    assign kp_inc    = kick_period_reg + pbts_pkg::KPER_W'(cfg.kick_step);
    assign kick_more = kp_inc < pbts_pkg::KPER_W'(cfg.kick_limit);
    assign sn_dec    = snare_timer_reg - pbts_pkg::CFG_W'(snare_timer_reg != '0);
    assign sn_end    = sn_dec == '0;
    assign noise_cur = (bit_idx_reg == '0) ? xorshift(noise_reg) : noise_reg;

    assign load_note_go = (head_item.beat_ticks != '0) && head_item.nz;
    assign tick_note_go = (bt_dec != '0) && note_nz_reg;
    assign per_half     = on_ticks_reg != '0;
    assign per_wc       = per_half ? on_ticks_reg : off_ticks_reg;
    assign load_half    = head_item.on_ticks != '0;
    assign load_wc      = load_half ? head_item.on_ticks : head_item.off_ticks;

    // next play phase
    always_comb
    begin
        phase_next = phase_reg;
        if (do_load)
        begin
            if (kick_go)
            begin
                phase_next = pbts_pkg::PH_KICK;
            end
            else if (snare_go)
            begin
                phase_next = pbts_pkg::PH_SNARE;
            end
            else
            begin
                phase_next = note_phase(head_item.beat_ticks == '0, head_item.nz);
            end
        end
        else if (do_tick)
        begin
            unique case (phase_reg)
                pbts_pkg::PH_KICK:
                begin
                    if (wc_end && !half_high_reg && !kick_more)
                    begin
                        phase_next = note_phase(bt_dec == '0, note_nz_reg);
                    end
                end
                pbts_pkg::PH_SNARE:
                begin
                    if (sn_end)
                    begin
                        phase_next = note_phase(bt_dec == '0, note_nz_reg);
                    end
                end
                pbts_pkg::PH_NOTE:
                begin
                    if (wc_end && !(half_high_reg && off_ticks_reg != '0) && bt_dec == '0)
                    begin
                        phase_next = pbts_pkg::PH_IDLE;
                    end
                end
                pbts_pkg::PH_REST:
                begin
                    if (bt_dec == '0)
                    begin
                        phase_next = pbts_pkg::PH_IDLE;
                    end
                end
                default: phase_next = pbts_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        beat_timer_next  = beat_timer_reg;
        noise_next       = noise_reg;
        wave_cnt_next    = wave_cnt_reg;
        half_high_next   = half_high_reg;
        kick_period_next = kick_period_reg;
        snare_timer_next = snare_timer_reg;
        on_ticks_next    = on_ticks_reg;
        off_ticks_next   = off_ticks_reg;
        note_nz_next     = note_nz_reg;
        bit_idx_next     = bit_idx_reg;
        pin_next         = pin_reg;
        if (do_load)
        begin
            beat_timer_next = head_item.beat_ticks;
            on_ticks_next   = head_item.on_ticks;
            off_ticks_next  = head_item.off_ticks;
            note_nz_next    = head_item.nz;
            if (kick_go)
            begin
                kick_period_next = pbts_pkg::KPER_W'(cfg.kick_min);
                half_high_next   = 1'b1;
                wave_cnt_next    = pbts_pkg::WAVE_W'(cfg.kick_min);
            end
            else if (snare_go)
            begin
                snare_timer_next = cfg.snare_ticks;
                bit_idx_next     = '0;
            end
            else if (load_note_go)
            begin
                half_high_next = load_half;
                wave_cnt_next  = load_wc;
            end
        end
        else if (do_tick)
        begin
            beat_timer_next = bt_dec;
            pin_next        = 1'b0;
            unique case (phase_reg)
                pbts_pkg::PH_KICK:
                begin
                    pin_next      = half_high_reg;
                    wave_cnt_next = wc_dec;
                    if (wc_end)
                    begin
                        if (half_high_reg)
                        begin
                            half_high_next = 1'b0;
                            wave_cnt_next  = pbts_pkg::WAVE_W'(kick_period_reg);
                        end
                        else
                        begin
                            kick_period_next = kp_inc;
                            if (kick_more)
                            begin
                                half_high_next = 1'b1;
                                wave_cnt_next  = pbts_pkg::WAVE_W'(kp_inc);
                            end
                            else if (tick_note_go)
                            begin
                                half_high_next = per_half;
                                wave_cnt_next  = per_wc;
                            end
                        end
                    end
                end
                pbts_pkg::PH_SNARE:
                begin
                    noise_next       = noise_cur;
                    pin_next         = noise_cur[bit_idx_reg];
                    bit_idx_next     = bit_idx_reg + pbts_pkg::NBIT_W'(1);
                    snare_timer_next = sn_dec;
                    if (sn_end && tick_note_go)
                    begin
                        half_high_next = per_half;
                        wave_cnt_next  = per_wc;
                    end
                end
                pbts_pkg::PH_NOTE:
                begin
                    pin_next      = half_high_reg;
                    wave_cnt_next = wc_dec;
                    if (wc_end)
                    begin
                        if (half_high_reg && off_ticks_reg != '0)
                        begin
                            half_high_next = 1'b0;
                            wave_cnt_next  = off_ticks_reg;
                        end
                        else if (bt_dec != '0)
                        begin
                            half_high_next = per_half;
                            wave_cnt_next  = per_wc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pbts_pkg::PH_IDLE;
            beat_timer_reg  <= '0;
            noise_reg       <= pbts_pkg::NOISE_SEED;
            wave_cnt_reg    <= '0;
            half_high_reg   <= 1'b0;
            kick_period_reg <= '0;
            snare_timer_reg <= '0;
            on_ticks_reg    <= '0;
            off_ticks_reg   <= '0;
            note_nz_reg     <= 1'b0;
            bit_idx_reg     <= '0;
            pin_reg         <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            beat_timer_reg  <= beat_timer_next;
            noise_reg       <= noise_next;
            wave_cnt_reg    <= wave_cnt_next;
            half_high_reg   <= half_high_next;
            kick_period_reg <= kick_period_next;
            snare_timer_reg <= snare_timer_next;
            on_ticks_reg    <= on_ticks_next;
            off_ticks_reg   <= off_ticks_next;
            note_nz_reg     <= note_nz_next;
            bit_idx_reg     <= bit_idx_next;
            pin_reg         <= pin_next;
        end
    end

    // result register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {refused, phase_next != pbts_pkg::PH_IDLE, pin_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

endmodule

@@ rtl/core/packed_beat_tone_sequencer_top.sv @@
// Top level of the packed beat tone sequencer: front pipeline, item queue
// and play back end. Depends on pbts_pkg, pbts_front, pbts_queue, pbts_back.
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  s_tdata: beat_word; s_tuser: opcode
// m_*       out        m_tvalid / m_tready  m_tdata: pin_level, beat_busy, load_refused
// wr_*      in         wr_en                wr_index, wr_data (24 bits)
//
// One item per cycle unless m_tready stalls the result register; m_tvalid rises once
// the input has passed the 3 front stages for the note period product, the queue and
// the result register; the back end keeps the same rate through its state machine.
// Up to 8 items wait in the front stages and queue, one more in the result register;
// s_tready drops when the queue credits run out.
// Reset is asynchronous, active low; configuration returns to its reset values.
module packed_beat_tone_sequencer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] beat_word
    input  logic [0:0]                     s_tuser,   // [0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] pin_level, [1] beat_busy,
                                                      // [2] load_refused, [7:3] zero
    input  logic                           wr_en,
    input  logic [pbts_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pbts_pkg::CFG_W-1:0]     wr_data
);

    logic                 pop;
    logic                 push;
    logic                 head_valid;
    pbts_pkg::pbts_item_t push_item;
    pbts_pkg::pbts_item_t head_item;
    pbts_pkg::pbts_cfg_t  cfg;

    pbts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .pop       (pop),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    pbts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    pbts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .cfg        (cfg),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ verif/tb_packed_beat_tone_sequencer_top.sv @@
// Self-checking testbench for packed_beat_tone_sequencer_top: beat loads and ticks
// go in over the input stream, pin/busy/refused results are checked against a predictor.
// Depends on pbts_pkg and the RTL top level only.
module tb_packed_beat_tone_sequencer_top;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;
    localparam logic [pbts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        opcode;
        logic [15:0] word;
    } beat_item_t;

    // Same bit order as m_tdata[2:0]
    typedef struct packed {
        logic load_refused;
        logic beat_busy;
        logic pin_level;
    } pin_status_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           wr_en = 1'b0;
    logic [pbts_pkg::CFG_IDX_W-1:0] wr_index = '0;
    logic [pbts_pkg::CFG_W-1:0]     wr_data = '0;

    beat_item_t  pending_items[$];
    pin_status_t expected_status[$];
    beat_item_t  next_item;
    int unsigned send_idle_pct = 36;
    int unsigned recv_stall_pct = 52;
    int unsigned mismatch_count = 0;

    // Configuration mirror
    logic [pbts_pkg::CFG_W-1:0] cfg_tps = pbts_pkg::TPS_RESET;
    logic [pbts_pkg::CFG_W-1:0] cfg_tpb = pbts_pkg::TPB_RESET;
    logic [pbts_pkg::CFG_W-1:0] cfg_snare = pbts_pkg::SNARE_RESET;

    // Predicted play state
    logic [27:0]            beat_left = '0;
    logic [31:0]            lfsr_word = pbts_pkg::NOISE_SEED;
    pbts_pkg::pbts_phase_t  tone_phase = pbts_pkg::PH_IDLE;
    logic [31:0]            wave_left = '0;
    logic                   wave_high = 1'b0;
    logic [31:0]            sweep_half = '0;
    logic [23:0]            noise_left = '0;
    logic [31:0]            on_len = '0;
    logic [31:0]            off_len = '0;
    logic [4:0]             noise_pos = '0;
    logic                   pin_state = 1'b0;

    // Semitone periods in Q0.24 for one octave
    bit [23:0] semi_q24 [12] = '{24'd16416466, 24'd15495081, 24'd14625409, 24'd13804548,
                                 24'd13029758, 24'd12298454, 24'd11608195, 24'd10956677,
                                 24'd10341726, 24'd9761289, 24'd9213430, 24'd8696320};

    packed_beat_tone_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] kick_min_of();
        return cfg_tps / 400;
    endfunction

    function automatic logic [31:0] kick_step_of();
        logic [31:0] step;
        step = (3 * kick_min_of()) / 5;
        return (step == 0) ? 32'd1 : step;
    endfunction

    function automatic logic [31:0] note_period(input logic [6:0] note);
        logic [63:0] prod;
        if (note == 0)
            return 32'd0;
        prod = cfg_tps * semi_q24[note % 12];
        return 32'(prod >> (27 + note / 12));
    endfunction

    function automatic void begin_wave_period();
        if (on_len != 0)
        begin
            wave_high = 1'b1;
            wave_left = on_len;
        end
        else
        begin
            wave_high = 1'b0;
            wave_left = off_len;
        end
    endfunction

    function automatic void enter_tone_phase();
        if (beat_left == 0)
            tone_phase = pbts_pkg::PH_IDLE;
        else if (on_len + off_len != 0)
        begin
            tone_phase = pbts_pkg::PH_NOTE;
            begin_wave_period();
        end
        else
            tone_phase = pbts_pkg::PH_REST;
    endfunction

    function automatic pin_status_t predict_item(input logic opcode, input logic [15:0] word);
        pin_status_t status;
        logic [2:0]  duty;
        logic [4:0]  beats;
        logic [31:0] beat_span;
        logic [31:0] period;
        logic [31:0] kmin;
        status.load_refused = 1'b0;
        kmin = kick_min_of();
        if (opcode == OP_LOAD)
        begin
            if (tone_phase != pbts_pkg::PH_IDLE)
                status.load_refused = 1'b1;
            else
            begin
                duty = {1'b0, word[7:6]} + 3'd1;
                beats = {1'b0, word[3:0]} + 5'd1;
                beat_span = cfg_tpb * beats;
                beat_left = beat_span[27:0];
                period = note_period(word[14:8]);
                on_len = period >> duty;
                off_len = period - on_len;
                // Kick wins over snare
                if (word[4] && kmin != 0)
                begin
                    tone_phase = pbts_pkg::PH_KICK;
                    sweep_half = kmin;
                    wave_high = 1'b1;
                    wave_left = kmin;
                end
                else if (!word[4] && word[5] && cfg_snare != 0)
                begin
                    tone_phase = pbts_pkg::PH_SNARE;
                    noise_left = cfg_snare;
                    noise_pos = '0;
                end
                else
                    enter_tone_phase();
            end
        end
        else
        begin
            if (beat_left != 0)
                beat_left = beat_left - 28'd1;
            case (tone_phase)
                pbts_pkg::PH_KICK:
                begin
                    pin_state = wave_high;
                    if (wave_left != 0)
                        wave_left = wave_left - 32'd1;
                    if (wave_left == 0)
                    begin
                        if (wave_high)
                        begin
                            wave_high = 1'b0;
                            wave_left = sweep_half;
                        end
                        else
                        begin
                            // Lengthen the half period; stop once it reaches four times the start
                            sweep_half = sweep_half + kick_step_of();
                            if (sweep_half < 4 * kmin)
                            begin
                                wave_high = 1'b1;
                                wave_left = sweep_half;
                            end
                            else
                                enter_tone_phase();
                        end
                    end
                end
                pbts_pkg::PH_SNARE:
                begin
                    if (noise_pos == 0)
                    begin
                        lfsr_word ^= lfsr_word << 13;
                        lfsr_word ^= lfsr_word >> 17;
                        lfsr_word ^= lfsr_word << 5;
                    end
                    pin_state = lfsr_word[noise_pos];
                    noise_pos = noise_pos + 5'd1;
                    if (noise_left != 0)
                        noise_left = noise_left - 24'd1;
                    if (noise_left == 0)
                        enter_tone_phase();
                end
                pbts_pkg::PH_NOTE:
                begin
                    pin_state = wave_high;
                    if (wave_left != 0)
                        wave_left = wave_left - 32'd1;
                    if (wave_left == 0)
                    begin
                        if (wave_high && off_len != 0)
                        begin
                            wave_high = 1'b0;
                            wave_left = off_len;
                        end
                        else if (beat_left == 0)
                            tone_phase = pbts_pkg::PH_IDLE;
                        else
                            begin_wave_period();
                    end
                end
                pbts_pkg::PH_REST:
                begin
                    pin_state = 1'b0;
                    if (beat_left == 0)
                        tone_phase = pbts_pkg::PH_IDLE;
                end
                default:
                begin
                    pin_state = 1'b0;
                    tone_phase = pbts_pkg::PH_IDLE;
                end
            endcase
        end
        status.pin_level = pin_state;
        status.beat_busy = (tone_phase != pbts_pkg::PH_IDLE);
        return status;
    endfunction

    // Rough tick count for a beat to run out under the current settings
    function automatic int unsigned beat_length_estimate(input logic [15:0] word);
        logic [31:0] span;
        logic [31:0] perc;
        logic [31:0] half;
        logic [31:0] kmin;
        span = cfg_tpb * ({1'b0, word[3:0]} + 5'd1);
        perc = 0;
        kmin = kick_min_of();
        if (word[4] && kmin != 0)
        begin
            for (half = kmin; half < 4 * kmin; half = half + kick_step_of())
                perc = perc + 2 * half;
        end
        else if (word[5])
            perc = 32'(cfg_snare);
        return ((span > perc) ? span : perc) + note_period(word[14:8]);
    endfunction

    task automatic note_mismatch(input string what, input pin_status_t want,
                                 input pin_status_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected pin=%0b busy=%0b refused=%0b, got pin=%0b busy=%0b refused=%0b",
                     $realtime, what, want.pin_level, want.beat_busy, want.load_refused,
                     got.pin_level, got.beat_busy, got.load_refused);
    endtask

    // Driver: present queued items, predict each one on its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_status.push_back(predict_item(s_tuser[0], s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_item.opcode;
                    s_tdata <= next_item.word;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                    note_mismatch("result with no pending prediction", '0,
                                  pin_status_t'(m_tdata[2:0]));
                else if (expected_status[0] !== pin_status_t'(m_tdata[2:0]))
                    note_mismatch("status mismatch", expected_status.pop_front(),
                                  pin_status_t'(m_tdata[2:0]));
                else
                    void'(expected_status.pop_front());
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic opcode, input logic [15:0] word);
        beat_item_t item;
        item.opcode = opcode;
        item.word = word;
        pending_items.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pbts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbts_pkg::CFG_W-1:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            pbts_pkg::REG_TICKS_PER_SECOND: cfg_tps = value;
            pbts_pkg::REG_TICKS_PER_BEAT:   cfg_tpb = value;
            pbts_pkg::REG_SNARE_TICKS:      cfg_snare = value;
            default:                        ;
        endcase
    endtask

    // Mostly whole beats (load, then ticks until it ends), some early loads and noise
    task automatic play_random(input int unsigned budget);
        int unsigned count;
        int unsigned span;
        int unsigned pick;
        logic [15:0] word;
        count = 0;
        while (count < budget)
        begin
            pick = $urandom_range(0, 99);
            word = 16'($urandom);
            if ($urandom_range(0, 9) < 7)
                word[14:8] = 7'($urandom_range(60, 127));
            if ($urandom_range(0, 9) < 7)
                word[3:0] = 4'($urandom_range(0, 3));
            if ($urandom_range(0, 2) != 0)
                word[4] = 1'b0;
            span = beat_length_estimate(word);
            if (pick < 80)
            begin
                push_item(OP_LOAD, word);
                span = span + $urandom_range(0, 2);
                repeat (span) push_item(OP_TICK, 16'($urandom));
                count += span + 1;
            end
            else if (pick < 92)
            begin
                // Cut the beat short so the next load lands while busy
                push_item(OP_LOAD, word);
                repeat (span / 2) push_item(OP_TICK, 16'($urandom));
                push_item(OP_LOAD, 16'($urandom));
                count += span / 2 + 2;
            end
            else
            begin
                push_item(1'($urandom), 16'($urandom));
                count += 1;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Idle ticks under reset settings
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'hFFFF);
        wait_drained();

        write_reg(pbts_pkg::REG_TICKS_PER_SECOND, 24'd1000);
        write_reg(pbts_pkg::REG_TICKS_PER_BEAT, 24'd2);
        write_reg(pbts_pkg::REG_SNARE_TICKS, 24'd3);
        write_reg(REG_UNUSED, 24'($urandom));

        push_item(OP_TICK, 16'h0000);
        push_item(OP_LOAD, 16'h0000);      // rest, one beat
        push_item(OP_LOAD, 16'h1234);      // refused while busy
        repeat (2) push_item(OP_TICK, 16'h0000);
        push_item(OP_LOAD, 16'h7FC0);      // top note has a zero period: plays as a rest
        repeat (2) push_item(OP_TICK, 16'h0000);
        push_item(OP_LOAD, 16'h3CC1);      // duty shift 4 leaves an all-low period
        repeat (6) push_item(OP_TICK, 16'h0000);
        push_item(OP_LOAD, 16'h4520);      // snare, then the beat is already over
        repeat (3) push_item(OP_TICK, 16'h0000);
        push_item(OP_LOAD, 16'hFFFF);      // kick over snare, sixteen beats
        play_random(130);
        // Hold the sender until every result is back
        wait_drained();
        play_random(80);
        wait_drained();

        send_idle_pct = 52;
        recv_stall_pct = 36;
        write_reg(pbts_pkg::REG_TICKS_PER_SECOND, 24'($urandom_range(1000, 2000)));
        write_reg(pbts_pkg::REG_TICKS_PER_BEAT, 24'($urandom_range(1, 6)));
        write_reg(pbts_pkg::REG_SNARE_TICKS, 24'($urandom_range(1, 12)));
        play_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(pbts_pkg::REG_TICKS_PER_SECOND, 24'd1999);
        write_reg(pbts_pkg::REG_TICKS_PER_BEAT, 24'd1);
        write_reg(pbts_pkg::REG_SNARE_TICKS, 24'd1);
        play_random(150);
        wait_drained();

        // Let the current beat finish before the largest settings
        while (tone_phase != pbts_pkg::PH_IDLE)
        begin
            push_item(OP_TICK, 16'($urandom));
            wait_drained();
        end
        write_reg(pbts_pkg::REG_TICKS_PER_SECOND, 24'hFFFFFF);
        write_reg(pbts_pkg::REG_TICKS_PER_BEAT, 24'hFFFFFF);
        write_reg(pbts_pkg::REG_SNARE_TICKS, 24'hFFFFFF);
        push_item(OP_LOAD, 16'h8A1F);
        repeat (40) push_item(OP_TICK, 16'($urandom));
        push_item(OP_LOAD, 16'h0025);
        repeat (5) push_item(OP_TICK, 16'($urandom));
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 200000);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pbts_pkg.sv
rtl/core/pbts_front.sv
rtl/core/pbts_queue.sv
rtl/core/pbts_back.sv
rtl/core/packed_beat_tone_sequencer_top.sv
verif/tb_packed_beat_tone_sequencer_top.sv
